// ===== hdl/reaction_wheel_torque_limiter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Reaction wheel torque limiter - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef REACTION_WHEEL_TORQUE_LIMITER_UNIT_MACROS_SVH
`define REACTION_WHEEL_TORQUE_LIMITER_UNIT_MACROS_SVH

// same-cycle implication
`define RWTL_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RWTL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rwtl_pkg.sv =====
// ----------------------------------------------------------------------------
// Reaction wheel torque limiter - package
// Widths, register indexes and the types shared by lanes, merge and top.
// ----------------------------------------------------------------------------
package rwtl_pkg;

	localparam int WHEEL_COUNT = 4;
	localparam int FIELD_W     = 16;
	localparam int LANE_STAGES = 6;

	localparam int LIM_W   = 15;
	localparam int RECIP_W = 24;
	localparam int FRAC_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_RECIP  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR_FRAC   = 2'd3;

	localparam logic [LIM_W-1:0]   TORQUE_LIMIT_RST = 15'd0;
	localparam logic [LIM_W-1:0]   SPEED_LIMIT_RST  = 15'd32767;
	localparam logic [RECIP_W-1:0] SPEED_RECIP_RST  = 24'd512;
	localparam logic [FRAC_W-1:0]  FLOOR_FRAC_RST   = 16'd0;

	typedef struct packed {
		logic [LIM_W-1:0]   torque_limit;
		logic [LIM_W-1:0]   speed_limit;
		logic [RECIP_W-1:0] speed_limit_reciprocal;
		logic [FRAC_W-1:0]  reversal_floor_fraction;
	} cfg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] torque;
		logic               sat;
	} lane_res_t;

endpackage

// ===== hdl/rwtl_lane.sv =====
// ----------------------------------------------------------------------------
// Reaction wheel torque limiter - wheel lane
// Six-stage pipeline: speed ratio, reversal fraction, reversal limit, clamp.
// ----------------------------------------------------------------------------
module rwtl_lane (
	input  logic                               clk,
	input  rwtl_pkg::cfg_t                     cfg,
	input  logic [rwtl_pkg::LANE_STAGES-1:0]   en,
	input  logic signed [rwtl_pkg::FIELD_W-1:0] speed,
	input  logic signed [rwtl_pkg::FIELD_W-1:0] torque,
	output rwtl_pkg::lane_res_t                res
);

	localparam logic [24:0] ONE24 = 25'h100_0000;
	localparam logic [16:0] ONE16 = 17'h1_0000;

	// stage 1: magnitudes, speed ratio product, threshold flags
	logic signed [16:0] sx, tx;
	logic [16:0] ms0, mt0;
	logic [40:0] prod0;
	logic        flag0;

	assign sx = {speed[15], speed};
	assign tx = {torque[15], torque};
	assign ms0 = speed[15]  ? 17'(-sx) : 17'(sx);
	assign mt0 = torque[15] ? 17'(-tx) : 17'(tx);
	assign prod0 = ms0 * cfg.speed_limit_reciprocal;
	assign flag0 = ((22'(mt0) * 22'd20) >= (22'(cfg.torque_limit) * 22'd19)) ||
		((22'(ms0) * 22'd20) >= (22'(cfg.speed_limit) * 22'd19));

	logic [40:0]        prod_s1;
	logic signed [15:0] spd_s1, trq_s1;
	logic [16:0]        mt_s1;
	logic               flag_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= prod0;
			spd_s1  <= speed;
			trq_s1  <= torque;
			mt_s1   <= mt0;
			flag_s1 <= flag0;
		end
	end

	// stage 2: saturate ratio at one, weight the speed-dependent part
	logic [24:0] ratio1, dist1;
	logic [16:0] wgt1;
	logic [41:0] prod2_c;

	assign ratio1 = (prod_s1 > 41'(ONE24)) ? ONE24 : prod_s1[24:0];
	assign dist1 = ONE24 - ratio1;
	assign wgt1 = ONE16 - 17'(cfg.reversal_floor_fraction);
	assign prod2_c = wgt1 * dist1;

	logic [40:0]        prod2_s2;
	logic signed [15:0] spd_s2, trq_s2;
	logic [16:0]        mt_s2;
	logic               flag_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod2_s2 <= prod2_c[40:0];
			spd_s2   <= spd_s1;
			trq_s2   <= trq_s1;
			mt_s2    <= mt_s1;
			flag_s2  <= flag_s1;
		end
	end

	// stage 3: add the floor term
	logic [40:0]        frac_s3;
	logic signed [15:0] spd_s3, trq_s3;
	logic [16:0]        mt_s3;
	logic               flag_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			frac_s3 <= {1'b0, cfg.reversal_floor_fraction, 24'b0} + prod2_s2;
			spd_s3  <= spd_s2;
			trq_s3  <= trq_s2;
			mt_s3   <= mt_s2;
			flag_s3 <= flag_s2;
		end
	end

	// stage 4: limit times fraction, split in two partial products
	logic [35:0]        ph_s4;
	logic [34:0]        pl_s4;
	logic signed [15:0] spd_s4, trq_s4;
	logic [16:0]        mt_s4;
	logic               flag_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ph_s4   <= cfg.torque_limit * frac_s3[40:20];
			pl_s4   <= cfg.torque_limit * frac_s3[19:0];
			spd_s4  <= spd_s3;
			trq_s4  <= trq_s3;
			mt_s4   <= mt_s3;
			flag_s4 <= flag_s3;
		end
	end

	// stage 5: combine partials, keep the integer part
	logic [55:0] sum4;
	assign sum4 = {ph_s4, 20'b0} + 56'(pl_s4);

	logic [15:0]        rev_s5;
	logic signed [15:0] spd_s5, trq_s5;
	logic [16:0]        mt_s5;
	logic               flag_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			rev_s5  <= sum4[55:40];
			spd_s5  <= spd_s4;
			trq_s5  <= trq_s4;
			mt_s5   <= mt_s4;
			flag_s5 <= flag_s4;
		end
	end

	// stage 6: clamp, reversal clip, speed block
	logic               opp5, neg5, blocked5, rev_flag5;
	logic [16:0]        lim5, rev17;
	logic [16:0]        mq_a5, mq_b5;
	logic signed [16:0] wl5, s17;
	logic [15:0]        tq5;

	always_comb begin
		lim5  = 17'(cfg.torque_limit);
		rev17 = 17'(rev_s5);
		wl5   = $signed({2'b0, cfg.speed_limit});
		s17   = {spd_s5[15], spd_s5};
		neg5  = trq_s5[15];
		opp5  = ((spd_s5 > 0) && (trq_s5 < 0)) || ((spd_s5 < 0) && (trq_s5 > 0));
		rev_flag5 = opp5 && (mt_s5 > rev17);
		mq_a5 = (mt_s5 > lim5) ? lim5 : mt_s5;
		mq_b5 = (opp5 && (mq_a5 > rev17)) ? rev17 : mq_a5;
		blocked5 = neg5 ? (s17 <= -wl5) : (s17 >= wl5);
		if (blocked5 || (mq_b5 == 17'd0))
			tq5 = '0;
		else if (neg5)
			tq5 = 16'(-mq_b5);
		else
			tq5 = mq_b5[15:0];
	end

	rwtl_pkg::lane_res_t res_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			res_s6.torque <= tq5;
			res_s6.sat    <= flag_s5 | rev_flag5;
		end
	end

	assign res = res_s6;

endmodule

// ===== hdl/rwtl_merge.sv =====
// ----------------------------------------------------------------------------
// Reaction wheel torque limiter - merge stage
// Packs lane torques, ORs lane saturation flags, holds the output request.
// ----------------------------------------------------------------------------
module rwtl_merge #(
	parameter int WHEEL_COUNT = rwtl_pkg::WHEEL_COUNT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  rwtl_pkg::lane_res_t                    res [WHEEL_COUNT],
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [WHEEL_COUNT*rwtl_pkg::FIELD_W-1:0] m_tdata,
	output logic                                   m_tuser
);

	localparam int FW = rwtl_pkg::FIELD_W;

	logic [WHEEL_COUNT*FW-1:0] data_c;
	logic                      sat_c;

	always_comb begin
		sat_c = 1'b0;
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			data_c[i*FW +: FW] = res[i].torque;
			sat_c = sat_c | res[i].sat;
		end
	end

	logic                      valid_q;
	logic [WHEEL_COUNT*FW-1:0] data_q;
	logic                      sat_q;

	assign in_ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_q <= data_c;
			sat_q  <= sat_c;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = sat_q;

endmodule

// ===== hdl/reaction_wheel_torque_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// Reaction wheel torque limiter unit
// Per-wheel torque clamp with speed-dependent reversal limit and speed block.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid/s_tready    s_tdata: speeds 0..N-1, torques 0..N-1
//   m_*       out  m_tvalid/m_tready    m_tdata: torques out, m_tuser: saturated
//   cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One command per cycle sustained while m_tready stays high; six lane stages set by
// the ratio, fraction and limit multipliers, plus the merge register.
// Reset clears stage valids and loads register defaults; cfg_ready is always 1.
// A stalled output holds its stage; earlier empty stages keep filling, so
// s_tready drops only when every stage holds a request.
// ----------------------------------------------------------------------------
`include "reaction_wheel_torque_limiter_unit_macros.svh"

module reaction_wheel_torque_limiter_unit #(
	parameter int WHEEL_COUNT = rwtl_pkg::WHEEL_COUNT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// wheel_speed_0..N-1, torque_request_0..N-1, 16 bits each, lowest first
	input  logic [2*WHEEL_COUNT*rwtl_pkg::FIELD_W-1:0] s_tdata,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// torque_out_0..N-1, 16 bits each, lowest first
	output logic [WHEEL_COUNT*rwtl_pkg::FIELD_W-1:0]   m_tdata,
	// saturated
	output logic                                     m_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [rwtl_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [rwtl_pkg::CFG_DATA_W-1:0]          cfg_data
);

	localparam int FW = rwtl_pkg::FIELD_W;
	localparam int NS = rwtl_pkg::LANE_STAGES;

	// configuration registers
	rwtl_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.torque_limit            <= rwtl_pkg::TORQUE_LIMIT_RST;
			cfg_q.speed_limit             <= rwtl_pkg::SPEED_LIMIT_RST;
			cfg_q.speed_limit_reciprocal  <= rwtl_pkg::SPEED_RECIP_RST;
			cfg_q.reversal_floor_fraction <= rwtl_pkg::FLOOR_FRAC_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rwtl_pkg::REG_TORQUE_LIMIT: cfg_q.torque_limit <= cfg_data[14:0];
				rwtl_pkg::REG_SPEED_LIMIT:  cfg_q.speed_limit  <= cfg_data[14:0];
				rwtl_pkg::REG_SPEED_RECIP:  cfg_q.speed_limit_reciprocal <= cfg_data;
				rwtl_pkg::REG_FLOOR_FRAC:   cfg_q.reversal_floor_fraction <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage valid chain; a stage advances when empty or when the next advances
	logic [NS-1:0] vld_q;
	logic [NS-1:0] adv;
	logic          merge_ready;

	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || merge_ready;
		for (int k = NS - 2; k >= 0; k--)
			adv[k] = !vld_q[k] || adv[k+1];
	end

	assign s_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= s_tvalid;
			for (int k = 1; k < NS; k++)
				if (adv[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// lanes
	rwtl_pkg::lane_res_t lane_res [WHEEL_COUNT];

	for (genvar i = 0; i < WHEEL_COUNT; i++) begin : g_lane
		rwtl_lane u_lane (
			.clk    (clk),
			.cfg    (cfg_q),
			.en     (adv),
			.speed  ($signed(s_tdata[i*FW +: FW])),
			.torque ($signed(s_tdata[(WHEEL_COUNT+i)*FW +: FW])),
			.res    (lane_res[i])
		);
	end

	rwtl_merge #(
		.WHEEL_COUNT (WHEEL_COUNT)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_q[NS-1]),
		.in_ready (merge_ready),
		.res      (lane_res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`RWTL_ASSERT(a_ready_only_when_full, !s_tready, vld_q[0], "input stalled with empty stage")
	`RWTL_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, vld_q[0], "accepted request lost")
	`RWTL_ASSERT_NEXT(a_last_stage_holds, vld_q[NS-1] && m_tvalid && !m_tready, vld_q[NS-1] && m_tvalid, "stalled request dropped")

endmodule
